[src/ugbp_pkg.sv]
// Package with shared types, command codes and defaults of the grid broadphase.
package ugbp_pkg;

  // Default sizes of the object set and of the grid side.
  localparam int MAX_OBJECTS_DEF = 64;
  localparam int MAX_SIDE_DEF    = 16;

  // Field widths.
  localparam int CMD_W    = 3;
  localparam int ID_W     = 6;
  localparam int POS_W    = 16;
  localparam int SIDEL_W  = 3;
  localparam int CSIZE_W  = 13;
  localparam int CFG_W    = 13;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ADD_CELL  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_COORD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd4;

  // Configuration register indexes.
  localparam logic REG_SIDE_LOG2 = 1'b0;
  localparam logic REG_CELL_SIZE = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  obj_id;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] max_x;
    logic [POS_W-1:0] max_y;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] hit_id;
    logic            found;
    logic            last;
  } out_item_t;

endpackage

[src/ugbp_div.sv]
// Restoring divider, one quotient bit per cycle, for coordinate to cell conversion.
module ugbp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ugbp_pkg::POS_W-1:0] dividend,
  input  logic [ugbp_pkg::CSIZE_W-1:0] divisor,
  output logic                       done,
  output logic [ugbp_pkg::POS_W-1:0] quotient
);
  import ugbp_pkg::*;

  localparam int CNT_W = $clog2(POS_W + 1);

  logic [CSIZE_W-1:0] rem_r, rem_nxt;
  logic [POS_W-1:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic [CSIZE_W:0]   shifted;
  logic [CSIZE_W:0]   diff;

  // One shift and trial subtract per cycle.
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[POS_W-1]};
    diff     = shifted - {1'b0, divisor};
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = CNT_W'(POS_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (shifted >= {1'b0, divisor}) begin
        rem_nxt = diff[CSIZE_W-1:0];
        quo_nxt = {quo_r[POS_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[CSIZE_W-1:0];
        quo_nxt = {quo_r[POS_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[src/ugbp_cmem.sv]
// Cell membership memory: one bitmap per cell, one write and one registered read port.
module ugbp_cmem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 64,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/uniform_grid_broadphase_unit.sv]
// Top level of the uniform grid broadphase: command sequencer around the cell memory.
//
// Commands arrive on in_valid/in_stall as one item each; only a query gives
// results on out_valid/out_stall, one item per hit id in ascending order with
// last set on the final one, or a single item with found low for an empty hit.
// The block works on one item at a time and stalls input until it is done.
// Add by cell steps through multiply, check-and-read and write states; add by
// coordinate runs two divisions first; remove checks the id, reads the recorded
// cell and clears the id bit there; clear sweeps the cell memory at one entry
// per cycle. A query runs four divisions, then reads one cell bitmap per cycle
// over the covered cells with a step at each row change, then scans ids up to
// the last hit at one per cycle while the output register is free; the single
// read port of the cell memory sets the walk. After reset the block sweeps the
// cell memory with in_stall high; configuration writes are taken at any time.
// A result waits in the output register while out_stall is high, and the id
// scan holds until that register frees up.
module uniform_grid_broadphase_unit #(
  parameter int MAX_OBJECTS = ugbp_pkg::MAX_OBJECTS_DEF,
  parameter int MAX_SIDE    = ugbp_pkg::MAX_SIDE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ugbp_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output ugbp_pkg::out_item_t          out_data,
  input  logic                         cfg_we,
  input  logic                         cfg_idx,
  input  logic [ugbp_pkg::CFG_W-1:0]   cfg_wdata
);
  import ugbp_pkg::*;

  localparam int CELL_COUNT = MAX_SIDE * MAX_SIDE;
  localparam int CIW        = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int OIW        = $clog2(MAX_OBJECTS);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CLR    = 4'd1;
  localparam logic [3:0] ST_DIVGO  = 4'd2;
  localparam logic [3:0] ST_DIVWT  = 4'd3;
  localparam logic [3:0] ST_MUL    = 4'd4;
  localparam logic [3:0] ST_ADDCHK = 4'd5;
  localparam logic [3:0] ST_ADDWR  = 4'd6;
  localparam logic [3:0] ST_RM0    = 4'd7;
  localparam logic [3:0] ST_RM1    = 4'd8;
  localparam logic [3:0] ST_RM2    = 4'd9;
  localparam logic [3:0] ST_QMUL   = 4'd10;
  localparam logic [3:0] ST_QWALK  = 4'd11;
  localparam logic [3:0] ST_EMIT   = 4'd12;

  logic [3:0]             state_r, state_nxt;
  logic [SIDEL_W-1:0]     side_log2_r;
  logic [CSIZE_W-1:0]     cell_size_r;
  in_item_t               item_r, item_nxt;
  logic [POS_W-1:0]       c0_r, c0_nxt, c1_r, c1_nxt, r0_r, r0_nxt, r1_r, r1_nxt;
  logic [1:0]             sel_r, sel_nxt;
  logic [23:0]            prod_r, prod_nxt;
  logic [23:0]            krow_r, krow_nxt;
  logic [POS_W:0]         j_r, j_nxt, c_r, c_nxt;
  logic [CIW-1:0]         clr_r, clr_nxt;
  logic [MAX_OBJECTS-1:0] present_r, present_nxt;
  logic [MAX_OBJECTS-1:0] hits_r, hits_nxt;
  logic                   pend_r;
  logic [OIW-1:0]         i_r, i_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  logic [CIW-1:0]         oc_mem [MAX_OBJECTS];
  logic [CIW-1:0]         oc_q_r;
  logic                   oc_we;

  logic [7:0]             side;
  logic [15:0]            area;
  logic [CSIZE_W-1:0]     divisor;
  logic [POS_W-1:0]       div_operand;
  logic                   div_start, div_done;
  logic [POS_W-1:0]       quotient;
  logic                   id_ok;
  logic [OIW-1:0]         id_idx;
  logic [MAX_OBJECTS-1:0] id_bit, i_bit;
  logic [24:0]            k_sum;
  logic                   slot_free;
  logic                   cm_we, cm_re;
  logic [CIW-1:0]         cm_waddr, cm_raddr;
  logic [MAX_OBJECTS-1:0] cm_wdata, cm_rdata;

  // Grid side saturates at MAX_SIDE; a zero cell size counts as one.
  always_comb begin
    side = 8'd1 << side_log2_r;
    if (32'(side) > MAX_SIDE) begin
      side = 8'(MAX_SIDE);
    end
    area    = 16'(side) * 16'(side);
    divisor = (cell_size_r == '0) ? CSIZE_W'(1) : cell_size_r;
  end

  assign id_ok  = 32'(item_r.obj_id) < MAX_OBJECTS;
  assign id_idx = item_r.obj_id[OIW-1:0];
  assign id_bit = MAX_OBJECTS'(1) << id_idx;
  assign i_bit  = MAX_OBJECTS'(1) << i_r;
  assign k_sum  = {1'b0, krow_r} + 25'(c_r);
  assign slot_free = !out_valid_r || !out_stall;

  // Divider operand order: min x, min y, max x, max y.
  always_comb begin
    case (sel_r)
      2'd0:    div_operand = item_r.pos_x;
      2'd1:    div_operand = item_r.pos_y;
      2'd2:    div_operand = item_r.max_x;
      default: div_operand = item_r.max_y;
    endcase
  end
  assign div_start = (state_r == ST_DIVGO);

  ugbp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_operand),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Sequencer: adds and removes walk read and write states; clear and query have their own.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    c0_nxt        = c0_r;
    c1_nxt        = c1_r;
    r0_nxt        = r0_r;
    r1_nxt        = r1_r;
    sel_nxt       = sel_r;
    prod_nxt      = prod_r;
    krow_nxt      = krow_r;
    j_nxt         = j_r;
    c_nxt         = c_r;
    clr_nxt       = clr_r;
    present_nxt   = present_r;
    hits_nxt      = pend_r ? (hits_r | cm_rdata) : hits_r;
    i_nxt         = i_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    cm_we         = 1'b0;
    cm_waddr      = prod_r[CIW-1:0];
    cm_wdata      = cm_rdata | id_bit;
    cm_re         = 1'b0;
    cm_raddr      = prod_r[CIW-1:0];
    oc_we         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          sel_nxt  = 2'd0;
          case (in_data.cmd)
            CMD_ADD_CELL: begin
              c0_nxt    = in_data.pos_x;
              r0_nxt    = in_data.pos_y;
              state_nxt = ST_MUL;
            end
            CMD_ADD_COORD: state_nxt = ST_DIVGO;
            CMD_REMOVE:    state_nxt = ST_RM0;
            CMD_QUERY: begin
              hits_nxt  = '0;
              state_nxt = ST_DIVGO;
            end
            CMD_CLEAR: begin
              clr_nxt     = '0;
              present_nxt = '0;
              state_nxt   = ST_CLR;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLR: begin
        cm_we    = 1'b1;
        cm_waddr = clr_r;
        cm_wdata = '0;
        clr_nxt  = clr_r + CIW'(1);
        if (32'(clr_r) == CELL_COUNT - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIVGO: state_nxt = ST_DIVWT;
      ST_DIVWT: begin
        if (div_done) begin
          case (sel_r)
            2'd0:    c0_nxt = quotient;
            2'd1:    r0_nxt = quotient;
            2'd2:    c1_nxt = quotient;
            default: r1_nxt = quotient;
          endcase
          sel_nxt = sel_r + 2'd1;
          if (item_r.cmd == CMD_QUERY) begin
            state_nxt = (sel_r == 2'd3) ? ST_QMUL : ST_DIVGO;
          end else begin
            state_nxt = (sel_r == 2'd1) ? ST_MUL : ST_DIVGO;
          end
        end
      end
      ST_MUL: begin
        prod_nxt  = 24'(r0_r) * 24'(side) + 24'(c0_r);
        state_nxt = ST_ADDCHK;
      end
      ST_ADDCHK: begin
        if (id_ok && prod_r < 24'(area)) begin
          cm_re     = 1'b1;
          state_nxt = ST_ADDWR;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ADDWR: begin
        cm_we       = 1'b1;
        oc_we       = 1'b1;
        present_nxt = present_r | id_bit;
        state_nxt   = ST_IDLE;
      end
      ST_RM0: begin
        state_nxt = (id_ok && present_r[id_idx]) ? ST_RM1 : ST_IDLE;
      end
      ST_RM1: begin
        present_nxt = present_r & ~id_bit;
        cm_raddr    = oc_q_r;
        if (16'(oc_q_r) < area) begin
          cm_re     = 1'b1;
          state_nxt = ST_RM2;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RM2: begin
        cm_we     = 1'b1;
        cm_waddr  = oc_q_r;
        cm_wdata  = cm_rdata & ~id_bit;
        state_nxt = ST_IDLE;
      end
      ST_QMUL: begin
        krow_nxt = 24'(r0_r) * 24'(side);
        j_nxt    = {1'b0, r0_r};
        c_nxt    = {1'b0, c0_r};
        i_nxt    = '0;
        state_nxt = (c0_r <= c1_r && r0_r <= r1_r) ? ST_QWALK : ST_EMIT;
      end
      ST_QWALK: begin
        // Walk columns of the current row, then step to the next row.
        cm_raddr = k_sum[CIW-1:0];
        if (krow_r >= 24'(area)) begin
          state_nxt = ST_EMIT;
        end else if (c_r <= {1'b0, c1_r} && k_sum < 25'(area)) begin
          cm_re = 1'b1;
          c_nxt = c_r + 17'd1;
        end else begin
          j_nxt    = j_r + 17'd1;
          krow_nxt = krow_r + 24'(side);
          c_nxt    = {1'b0, c0_r};
          if (j_r >= {1'b0, r1_r}) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        // Scan hit ids in ascending order, one id per cycle while the output register is free.
        if (hits_r == '0) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{hit_id: '0, found: 1'b0, last: 1'b1};
            state_nxt     = ST_IDLE;
          end
        end else if (hits_r[i_r]) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{hit_id: ID_W'(i_r), found: 1'b1,
                              last: ((hits_r & ~i_bit) == '0)};
            hits_nxt      = hits_r & ~i_bit;
            i_nxt         = i_r + OIW'(1);
            if ((hits_r & ~i_bit) == '0) begin
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          i_nxt = i_r + OIW'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  ugbp_cmem #(
    .DEPTH (CELL_COUNT),
    .WIDTH (MAX_OBJECTS),
    .AW    (CIW)
  ) u_cmem (
    .clk     (clk),
    .wr_en   (cm_we),
    .wr_addr (cm_waddr),
    .wr_data (cm_wdata),
    .rd_en   (cm_re),
    .rd_addr (cm_raddr),
    .rd_data (cm_rdata)
  );

  // Recorded cell of each object, read at the current object id.
  always_ff @(posedge clk) begin
    if (oc_we) begin
      oc_mem[id_idx] <= prod_r[CIW-1:0];
    end
    oc_q_r <= oc_mem[id_idx];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    c0_r       <= c0_nxt;
    c1_r       <= c1_nxt;
    r0_r       <= r0_nxt;
    r1_r       <= r1_nxt;
    sel_r      <= sel_nxt;
    prod_r     <= prod_nxt;
    krow_r     <= krow_nxt;
    j_r        <= j_nxt;
    c_r        <= c_nxt;
    hits_r     <= hits_nxt;
    i_r        <= i_nxt;
    out_data_r <= out_data_nxt;
  end

  // Control registers; reset starts the memory clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      present_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      side_log2_r <= SIDEL_W'(4);
      cell_size_r <= CSIZE_W'(64);
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      present_r   <= present_nxt;
      pend_r      <= cm_re && (state_r == ST_QWALK);
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_idx == REG_SIDE_LOG2) begin
        side_log2_r <= cfg_wdata[SIDEL_W-1:0];
      end
      if (cfg_we && cfg_idx == REG_CELL_SIZE) begin
        cell_size_r <= cfg_wdata[CSIZE_W-1:0];
      end
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/ugbp_checker.sv]
// Port-level checker for the grid broadphase, bound to the top level.
module ugbp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ugbp_pkg::out_item_t out_data
);
  import ugbp_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The block is busy clearing right after reset.
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during clearing sweep");

  // An empty query result is always the final one.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.last && out_data.hit_id == '0)
    else $error("empty result without last");

  // A new result only appears while a query holds the input off.
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a running query");

endmodule

bind uniform_grid_broadphase_unit ugbp_checker u_ugbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
